// ===== design/pts_pkg.sv =====
// Package for the priority task scheduler: opcodes, task states, result status
// codes and the command/status types between controller and datapath.
// No dependencies.
`default_nettype none

package pts_pkg;

  localparam logic [3:0] OP_CREATE  = 4'd0;
  localparam logic [3:0] OP_DELETE  = 4'd1;
  localparam logic [3:0] OP_SLEEP   = 4'd2;
  localparam logic [3:0] OP_TICK    = 4'd3;
  localparam logic [3:0] OP_YIELD   = 4'd4;
  localparam logic [3:0] OP_SEMINIT = 4'd5;
  localparam logic [3:0] OP_TAKE    = 4'd6;
  localparam logic [3:0] OP_TRYTAKE = 4'd7;
  localparam logic [3:0] OP_GIVE    = 4'd8;

  localparam logic [2:0] ST_EMPTY = 3'd0;
  localparam logic [2:0] ST_READY = 3'd1;
  localparam logic [2:0] ST_SLEEP = 3'd2;
  localparam logic [2:0] ST_BLOCK = 3'd3;
  localparam logic [2:0] ST_DEL   = 3'd4;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NOSLOT  = 2'd1;
  localparam logic [1:0] STAT_SEMBUSY = 2'd2;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_CAPTURE,
    DP_CREATE,
    DP_DELETE,
    DP_SLEEP,
    DP_TICK,
    DP_SEMINIT,
    DP_TAKE,
    DP_TRY,
    DP_GIVE,
    DP_WAKE,
    DP_RS_START,
    DP_RS_STEP,
    DP_FINISH
  } dp_op_e;

  typedef struct packed {
    logic hit;
    logic last;
    logic ti_ok;
    logic sem_ok;
    logic cnt_pos;
    logic cnt_below;
    logic on_running;
    logic none_ready;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== design/pts_datapath.sv =====
// Datapath of the priority task scheduler: task table, ready counts and bitmap,
// semaphore table, slot pointer and result registers. Depends on pts_pkg.
`default_nettype none

module pts_datapath #(
  parameter int TASK_SLOTS      = 8,
  parameter int PRIORITY_LEVELS = 8,
  parameter int SEMAPHORES      = 4,
  parameter int DELAY_BITS      = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pts_pkg::dp_op_e   cmd_i,
  input  logic [3:0]        opcode_i,
  input  logic [2:0]        task_index_i,
  input  logic [2:0]        priority_req_i,
  input  logic [15:0]       delay_i,
  input  logic [1:0]        sem_index_i,
  input  logic signed [7:0] sem_max_i,
  input  logic signed [7:0] sem_initial_i,
  output pts_pkg::dp_stat_t stat_o,
  output logic [1:0]        status_o,
  output logic [2:0]        created_slot_o,
  output logic [2:0]        current_task_o,
  output logic [7:0]        ready_mask_o
);
  import pts_pkg::*;

  localparam int SW  = $clog2(TASK_SLOTS);
  localparam int UW  = $clog2(TASK_SLOTS + 1);
  localparam int PW  = $clog2(PRIORITY_LEVELS);
  localparam int SMW = (SEMAPHORES > 1) ? $clog2(SEMAPHORES) : 1;

  logic [2:0]            state_q [TASK_SLOTS];
  logic [PW-1:0]         pri_q   [TASK_SLOTS];
  logic [DELAY_BITS-1:0] sleep_q [TASK_SLOTS];
  logic                  wv_q    [TASK_SLOTS];
  logic [SMW-1:0]        wsem_q  [TASK_SLOTS];
  logic [UW-1:0]         rpp_q   [PRIORITY_LEVELS];
  logic [PRIORITY_LEVELS-1:0] bitmap_q;
  logic [UW-1:0]         used_q;
  logic [SW-1:0]         run_q;
  logic signed [7:0]     sc_q [SEMAPHORES];
  logic signed [7:0]     sl_q [SEMAPHORES];

  logic [2:0]            ti_q;
  logic [PW-1:0]         pr_q;
  logic [DELAY_BITS-1:0] dl_q;
  logic [1:0]            si_q;
  logic signed [7:0]     smax_q;
  logic signed [7:0]     sinit_q;
  logic [SW-1:0]         idx_q;
  logic [SW-1:0]         k_q;
  logic [PW-1:0]         top_q;
  logic [1:0]            stat_q;
  logic [SW-1:0]         created_q;

  logic [2:0]            cur_st;
  logic [PW-1:0]         cur_pri;
  logic [DELAY_BITS-1:0] cur_sl;
  logic [DELAY_BITS-1:0] sl_dec;
  logic [SMW-1:0]        sidx;
  logic signed [7:0]     cnt;
  logic signed [7:0]     lim;
  logic                  sem_ok;
  logic                  cnt_pos;
  logic                  cnt_below;
  logic                  last_used;
  logic [SW-1:0]         idx_next;
  logic [SW-1:0]         run_next;
  logic                  hi_nz;
  logic                  eligible;
  logic                  wake_hit;
  logic                  free_hit;
  logic [PW-1:0]         top;

  logic                  ss_en;
  logic [2:0]            ss_ns;
  logic [PW-1:0]         ss_p;
  logic [UW-1:0]         rpp_cur;
  logic [UW-1:0]         rpp_new;
  logic                  ss_dec;
  logic                  ss_inc;

  assign cur_st    = state_q[idx_q];
  assign cur_pri   = pri_q[idx_q];
  assign cur_sl    = sleep_q[idx_q];
  assign sl_dec    = (cur_sl == '0) ? '0 : cur_sl - DELAY_BITS'(1);
  assign sidx      = SMW'(si_q);
  assign sem_ok    = 32'(si_q) < SEMAPHORES;
  assign cnt       = sc_q[sidx];
  assign lim       = sl_q[sidx];
  assign cnt_pos   = cnt > 8'sd0;
  assign cnt_below = cnt < lim;
  assign last_used = (UW'(idx_q) + UW'(1)) >= used_q;
  assign idx_next  = last_used ? '0 : idx_q + SW'(1);
  assign run_next  = ((UW'(run_q) + UW'(1)) >= used_q) ? '0 : run_q + SW'(1);
  assign hi_nz     = |bitmap_q[PRIORITY_LEVELS-1:1];
  // Idle slot 0 only competes when priority 0 is the sole ready level.
  assign eligible  = !(idx_q == '0 && hi_nz) && cur_st == ST_READY && cur_pri == top_q;
  assign wake_hit  = cur_st == ST_BLOCK && wv_q[idx_q] && wsem_q[idx_q] == sidx;
  assign free_hit  = cur_st == ST_EMPTY || cur_st == ST_DEL;

  always_comb begin
    top = '0;
    for (int p = 0; p < PRIORITY_LEVELS; p++) begin
      if (bitmap_q[p]) top = PW'(p);
    end
  end

  always_comb begin
    stat_o            = '0;
    stat_o.ti_ok      = 32'(ti_q) < TASK_SLOTS;
    stat_o.sem_ok     = sem_ok;
    stat_o.cnt_pos    = cnt_pos;
    stat_o.cnt_below  = cnt_below;
    stat_o.on_running = idx_q == run_q;
    stat_o.none_ready = bitmap_q == '0;
    case (cmd_i)
      DP_CREATE: begin
        stat_o.hit  = free_hit;
        stat_o.last = idx_q == SW'(TASK_SLOTS - 1);
      end
      DP_TICK: stat_o.last = last_used;
      DP_WAKE: begin
        stat_o.hit  = wake_hit;
        stat_o.last = last_used;
      end
      DP_RS_STEP: begin
        stat_o.hit  = eligible;
        stat_o.last = UW'(k_q) == used_q - UW'(1);
      end
      default: ;
    endcase
  end

  // One task state change per cycle, with its ready count and bitmap update.
  always_comb begin
    ss_en = 1'b0;
    ss_ns = cur_st;
    ss_p  = cur_pri;
    case (cmd_i)
      DP_CREATE: begin
        if (free_hit) begin
          ss_en = 1'b1;
          ss_ns = ST_READY;
          ss_p  = pr_q;
        end
      end
      DP_DELETE: begin
        ss_en = 1'b1;
        ss_ns = ST_DEL;
      end
      DP_SLEEP: begin
        ss_en = 1'b1;
        ss_ns = ST_SLEEP;
      end
      DP_TICK: begin
        if (cur_st == ST_SLEEP && sl_dec == '0) begin
          ss_en = 1'b1;
          ss_ns = ST_READY;
        end
      end
      DP_TAKE: begin
        if (!cnt_pos) begin
          ss_en = 1'b1;
          ss_ns = ST_BLOCK;
        end
      end
      DP_WAKE: begin
        if (wake_hit) begin
          ss_en = 1'b1;
          ss_ns = ST_READY;
        end
      end
      default: ;
    endcase
  end

  assign rpp_cur = rpp_q[ss_p];
  assign ss_dec  = ss_en && cur_st == ST_READY && ss_ns != ST_READY && rpp_cur != '0;
  assign ss_inc  = ss_en && ss_ns == ST_READY && cur_st != ST_READY;
  assign rpp_new = ss_dec ? rpp_cur - UW'(1) : (ss_inc ? rpp_cur + UW'(1) : rpp_cur);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
        state_q[i] <= (i == 0) ? ST_READY : ST_EMPTY;
        pri_q[i]   <= '0;
        sleep_q[i] <= '0;
        wv_q[i]    <= 1'b0;
        wsem_q[i]  <= '0;
      end
      for (int p = 0; p < PRIORITY_LEVELS; p++) begin
        rpp_q[p] <= (p == 0) ? UW'(1) : '0;
      end
      for (int s = 0; s < SEMAPHORES; s++) begin
        sc_q[s] <= '0;
        sl_q[s] <= '0;
      end
      bitmap_q       <= PRIORITY_LEVELS'(1);
      used_q         <= UW'(1);
      run_q          <= '0;
      ti_q           <= '0;
      pr_q           <= '0;
      dl_q           <= '0;
      si_q           <= '0;
      smax_q         <= '0;
      sinit_q        <= '0;
      idx_q          <= '0;
      k_q            <= '0;
      top_q          <= '0;
      stat_q         <= STAT_OK;
      created_q      <= '0;
      status_o       <= STAT_OK;
      created_slot_o <= '0;
      current_task_o <= '0;
      ready_mask_o   <= '0;
    end else begin
      if (ss_en) begin
        state_q[idx_q] <= ss_ns;
        rpp_q[ss_p]    <= rpp_new;
        if (ss_dec && rpp_cur == UW'(1)) bitmap_q[ss_p] <= 1'b0;
        if (ss_inc) bitmap_q[ss_p] <= 1'b1;
      end
      case (cmd_i)
        DP_CAPTURE: begin
          ti_q      <= task_index_i;
          pr_q      <= (32'(priority_req_i) >= PRIORITY_LEVELS) ?
                       PW'(PRIORITY_LEVELS - 1) : PW'(priority_req_i);
          dl_q      <= DELAY_BITS'(delay_i);
          si_q      <= sem_index_i;
          smax_q    <= sem_max_i;
          sinit_q   <= sem_initial_i;
          stat_q    <= STAT_OK;
          created_q <= '0;
          if (opcode_i == OP_DELETE) begin
            idx_q <= SW'(task_index_i);
          end else if (opcode_i == OP_SLEEP || opcode_i == OP_TAKE) begin
            idx_q <= run_q;
          end else begin
            idx_q <= '0;
          end
        end
        DP_CREATE: begin
          if (free_hit) begin
            pri_q[idx_q]   <= pr_q;
            sleep_q[idx_q] <= '0;
            wv_q[idx_q]    <= 1'b0;
            wsem_q[idx_q]  <= '0;
            created_q      <= idx_q;
            if ((UW'(idx_q) + UW'(1)) > used_q) used_q <= UW'(idx_q) + UW'(1);
          end else if (idx_q == SW'(TASK_SLOTS - 1)) begin
            stat_q <= STAT_NOSLOT;
          end else begin
            idx_q <= idx_q + SW'(1);
          end
        end
        DP_DELETE: wv_q[idx_q] <= 1'b0;
        DP_SLEEP:  sleep_q[idx_q] <= dl_q;
        DP_TICK: begin
          if (cur_st == ST_SLEEP) sleep_q[idx_q] <= sl_dec;
          if (!last_used) idx_q <= idx_q + SW'(1);
        end
        DP_SEMINIT: begin
          sl_q[sidx] <= smax_q;
          sc_q[sidx] <= sinit_q;
        end
        DP_TAKE: begin
          if (cnt_pos) begin
            sc_q[sidx] <= cnt - 8'sd1;
          end else begin
            wv_q[idx_q]   <= 1'b1;
            wsem_q[idx_q] <= sidx;
            stat_q        <= STAT_SEMBUSY;
          end
        end
        DP_TRY: begin
          if (cnt_pos) sc_q[sidx] <= cnt - 8'sd1;
          else stat_q <= STAT_SEMBUSY;
        end
        DP_GIVE: begin
          if (cnt_below) begin
            sc_q[sidx] <= cnt + 8'sd1;
            idx_q      <= '0;
          end
        end
        DP_WAKE: begin
          if (wake_hit) begin
            wv_q[idx_q]   <= 1'b0;
            wsem_q[idx_q] <= '0;
          end else if (!last_used) begin
            idx_q <= idx_q + SW'(1);
          end
        end
        DP_RS_START: begin
          if (bitmap_q == '0) run_q <= '0;
          idx_q <= run_next;
          k_q   <= '0;
          top_q <= top;
        end
        DP_RS_STEP: begin
          if (eligible) begin
            run_q <= idx_q;
          end else if (UW'(k_q) == used_q - UW'(1)) begin
            run_q <= '0;
          end else begin
            idx_q <= idx_next;
            k_q   <= k_q + SW'(1);
          end
        end
        DP_FINISH: begin
          status_o       <= stat_q;
          created_slot_o <= 3'(created_q);
          current_task_o <= 3'(run_q);
          ready_mask_o   <= 8'(bitmap_q);
        end
        default: ;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_run_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    UW'(run_q) < used_q) else $error("running task beyond used slots");
  a_used_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q != '0 && used_q <= UW'(TASK_SLOTS)) else $error("used slot count out of bounds");
  a_idle_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bitmap_q[0] == (rpp_q[0] != '0)) else $error("bitmap disagrees with level 0 count");
`endif

endmodule

`default_nettype wire

// ===== design/pts_ctrl.sv =====
// Controller of the priority task scheduler: sequences each command through
// the datapath and runs both handshakes. Depends on pts_pkg.
`default_nettype none

module pts_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [3:0]        opcode_i,
  input  pts_pkg::dp_stat_t stat_i,
  output pts_pkg::dp_op_e   cmd_o,
  output logic              out_valid_o,
  input  logic              out_ready_i
);
  import pts_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISPATCH = 4'd1;
  localparam logic [3:0] S_CREATE   = 4'd2;
  localparam logic [3:0] S_DELETE   = 4'd3;
  localparam logic [3:0] S_SLEEP    = 4'd4;
  localparam logic [3:0] S_TICK     = 4'd5;
  localparam logic [3:0] S_SEMINIT  = 4'd6;
  localparam logic [3:0] S_TAKE     = 4'd7;
  localparam logic [3:0] S_TRY      = 4'd8;
  localparam logic [3:0] S_GIVE     = 4'd9;
  localparam logic [3:0] S_WAKE     = 4'd10;
  localparam logic [3:0] S_RS_START = 4'd11;
  localparam logic [3:0] S_RS_SCAN  = 4'd12;
  localparam logic [3:0] S_DONE     = 4'd13;

  logic [3:0] state_q, state_d;
  logic [3:0] op_q, op_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;

  assign in_ready_o  = state_q == S_IDLE && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    cmd_o       = DP_NOP;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o   = DP_CAPTURE;
          op_d    = opcode_i;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (op_q)
          OP_CREATE:  state_d = S_CREATE;
          OP_DELETE:  state_d = stat_i.ti_ok ? S_DELETE : S_DONE;
          OP_SLEEP:   state_d = S_SLEEP;
          OP_TICK:    state_d = S_TICK;
          OP_YIELD:   state_d = S_RS_START;
          OP_SEMINIT: state_d = stat_i.sem_ok ? S_SEMINIT : S_DONE;
          OP_TAKE:    state_d = stat_i.sem_ok ? S_TAKE : S_DONE;
          OP_TRYTAKE: state_d = stat_i.sem_ok ? S_TRY : S_DONE;
          OP_GIVE:    state_d = stat_i.sem_ok ? S_GIVE : S_DONE;
          default:    state_d = S_DONE;
        endcase
      end
      S_CREATE: begin
        cmd_o = DP_CREATE;
        if (stat_i.hit || stat_i.last) state_d = S_DONE;
      end
      S_DELETE: begin
        cmd_o   = DP_DELETE;
        state_d = stat_i.on_running ? S_RS_START : S_DONE;
      end
      S_SLEEP: begin
        cmd_o   = DP_SLEEP;
        state_d = S_RS_START;
      end
      S_TICK: begin
        cmd_o = DP_TICK;
        if (stat_i.last) state_d = S_RS_START;
      end
      S_SEMINIT: begin
        cmd_o   = DP_SEMINIT;
        state_d = S_DONE;
      end
      S_TAKE: begin
        cmd_o   = DP_TAKE;
        state_d = stat_i.cnt_pos ? S_DONE : S_RS_START;
      end
      S_TRY: begin
        cmd_o   = DP_TRY;
        state_d = S_DONE;
      end
      S_GIVE: begin
        cmd_o   = DP_GIVE;
        state_d = stat_i.cnt_below ? S_WAKE : S_DONE;
      end
      S_WAKE: begin
        cmd_o = DP_WAKE;
        if (stat_i.hit || stat_i.last) state_d = S_DONE;
      end
      S_RS_START: begin
        cmd_o   = DP_RS_START;
        state_d = stat_i.none_ready ? S_DONE : S_RS_SCAN;
      end
      S_RS_SCAN: begin
        cmd_o = DP_RS_STEP;
        if (stat_i.hit || stat_i.last) state_d = S_DONE;
      end
      S_DONE: begin
        cmd_o       = DP_FINISH;
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef ASSERT_OFF
  a_done_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE |-> !out_valid_q) else $error("result register still occupied");
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_DISPATCH) else $error("accepted command not dispatched");
  a_done_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE |=> out_valid_q) else $error("finished command gave no result");
`endif

endmodule

`default_nettype wire

// ===== design/priority_task_scheduler_top.sv =====
// Priority task scheduler top level: joins the controller and the datapath.
// Depends on pts_pkg, pts_ctrl and pts_datapath.
//
// Usage: one command transaction enters on the in_* channel (valid/ready) and
// exactly one result transaction leaves on the out_* channel (valid/ready).
// Commands are processed one at a time. A command is captured in the accepting
// cycle and then dispatched; it then does its work, and the result is loaded,
// which is valid in the following cycle. The work per opcode:
//   sleep, take that blocks, delete of the running task: a reschedule,
//   yield: a reschedule; give below its limit: a scan for a waiting task to wake,
//   create: a search for a free slot,
//   tick: a scan of the used slots, then a reschedule,
//   semaphore init, try take, take that succeeds, delete of another task: no scan,
//   unknown opcode: none.
// The slot scans of create, tick, give and the round-robin reschedule visit
// one task table entry per cycle. The next command can
// be accepted in the cycle after the result is loaded.
// After reset slot 0 (the idle task) is ready at priority 0 and runs, all
// other slots are empty and all semaphores hold zero.
// The result sits in an output register; if the receiver stalls, it holds
// there and the next command is accepted in the cycle it is taken.
`default_nettype none

module priority_task_scheduler_top #(
  parameter int TASK_SLOTS      = 8,
  parameter int PRIORITY_LEVELS = 8,
  parameter int SEMAPHORES      = 4,
  parameter int DELAY_BITS      = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [3:0]        opcode_i,
  input  logic [2:0]        task_index_i,
  input  logic [2:0]        priority_req_i,
  input  logic [15:0]       delay_i,
  input  logic [1:0]        sem_index_i,
  input  logic signed [7:0] sem_max_i,
  input  logic signed [7:0] sem_initial_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        status_o,
  output logic [2:0]        created_slot_o,
  output logic [2:0]        current_task_o,
  output logic [7:0]        ready_mask_o
);
  import pts_pkg::*;

  dp_op_e   cmd;
  dp_stat_t stat;

  pts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .opcode_i   (opcode_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i)
  );

  pts_datapath #(
    .TASK_SLOTS     (TASK_SLOTS),
    .PRIORITY_LEVELS(PRIORITY_LEVELS),
    .SEMAPHORES     (SEMAPHORES),
    .DELAY_BITS     (DELAY_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .opcode_i      (opcode_i),
    .task_index_i  (task_index_i),
    .priority_req_i(priority_req_i),
    .delay_i       (delay_i),
    .sem_index_i   (sem_index_i),
    .sem_max_i     (sem_max_i),
    .sem_initial_i (sem_initial_i),
    .stat_o        (stat),
    .status_o      (status_o),
    .created_slot_o(created_slot_o),
    .current_task_o(current_task_o),
    .ready_mask_o  (ready_mask_o)
  );

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for priority_task_scheduler_top: a command driver, a
// result monitor and a scheduler predictor that checks every result transaction.
// Depends on pts_pkg and the scheduler RTL.
`timescale 1ns / 1ps

module tb;
  import pts_pkg::*;

  typedef struct packed {
    logic [3:0]        opcode;
    logic [2:0]        task_index;
    logic [2:0]        priority_req;
    logic [15:0]       delay;
    logic [1:0]        sem_index;
    logic signed [7:0] sem_max;
    logic signed [7:0] sem_initial;
  } cmd_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] created_slot;
    logic [2:0] current_task;
    logic [7:0] ready_mask;
  } sched_result_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic [3:0] opcode_i;
  logic [2:0] task_index_i, priority_req_i;
  logic [15:0] delay_i;
  logic [1:0] sem_index_i;
  logic signed [7:0] sem_max_i, sem_initial_i;
  logic [1:0] status_o;
  logic [2:0] created_slot_o, current_task_o;
  logic [7:0] ready_mask_o;

  priority_task_scheduler_top DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .opcode_i, .task_index_i,
    .priority_req_i, .delay_i, .sem_index_i, .sem_max_i, .sem_initial_i,
    .out_valid_o, .out_ready_i, .status_o, .created_slot_o, .current_task_o,
    .ready_mask_o
  );

  // Predictor copy of the scheduler state.
  logic [2:0]         m_state [8];
  logic [2:0]         m_prio [8];
  logic [15:0]        m_sleep [8];
  logic               m_wvalid [8];
  logic [1:0]         m_wsem [8];
  logic [3:0]         m_rdy_cnt [8];
  logic [7:0]         m_bitmap;
  logic [3:0]         m_used;
  logic [2:0]         m_running;
  logic signed [7:0]  m_sem_cnt [4];
  logic signed [7:0]  m_sem_lim [4];

  cmd_t          pending_cmds[$];
  sched_result_t expected_results[$];
  bit            failed;
  bit            sender_paused;
  bit            rx_hold;
  bit            no_idle;
  int            hold_cycles;

  function automatic void model_reset();
    for (int i = 0; i < 8; i++) begin
      m_state[i] = ST_EMPTY; m_prio[i] = 0; m_sleep[i] = 0;
      m_wvalid[i] = 0; m_wsem[i] = 0; m_rdy_cnt[i] = 0;
    end
    for (int i = 0; i < 4; i++) begin
      m_sem_cnt[i] = 0; m_sem_lim[i] = 0;
    end
    m_state[0] = ST_READY; m_rdy_cnt[0] = 1; m_bitmap = 8'h01;
    m_used = 1; m_running = 0;
  endfunction

  function automatic void move_task(int idx, logic [2:0] ns);
    logic [2:0] p;
    p = m_prio[idx];
    if (m_state[idx] == ns) return;
    if (m_state[idx] == ST_READY && m_rdy_cnt[p] > 0) begin
      m_rdy_cnt[p]--;
      if (m_rdy_cnt[p] == 0) m_bitmap[p] = 1'b0;
    end
    if (ns == ST_READY) begin
      m_bitmap[p] = 1'b1;
      m_rdy_cnt[p]++;
    end
    m_state[idx] = ns;
  endfunction

  function automatic void pick_next_task();
    int top, nxt, n;
    top = 0;
    if (m_bitmap == 0) begin
      m_running = 0;
      return;
    end
    for (int p = 7; p >= 0; p--)
      if (m_bitmap[p]) begin
        top = p;
        break;
      end
    n = (m_used < 1) ? 1 : m_used;
    nxt = m_running;
    for (int k = 0; k < n; k++) begin
      nxt++;
      if (nxt >= n) nxt = 0;
      // The idle slot only runs when nothing above priority 0 is ready.
      if (nxt == 0 && m_bitmap > 1) continue;
      if (m_state[nxt] == ST_READY && m_prio[nxt] == top) begin
        m_running = 3'(nxt);
        return;
      end
    end
    m_running = 0;
  endfunction

  function automatic sched_result_t run_command(cmd_t c);
    sched_result_t r;
    int i;
    r = '0;
    case (c.opcode)
      OP_CREATE: begin
        for (i = 0; i < 8; i++)
          if (m_state[i] == ST_EMPTY || m_state[i] == ST_DEL) break;
        if (i >= 8) r.status = STAT_NOSLOT;
        else begin
          if (i + 1 > m_used) m_used = 4'(i + 1);
          m_sleep[i] = 0; m_wvalid[i] = 0; m_wsem[i] = 0;
          m_prio[i] = c.priority_req;
          move_task(i, ST_READY);
          r.created_slot = 3'(i);
        end
      end
      OP_DELETE: begin
        move_task(c.task_index, ST_DEL);
        m_wvalid[c.task_index] = 0;
        if (c.task_index == m_running) pick_next_task();
      end
      OP_SLEEP: begin
        m_sleep[m_running] = c.delay;
        move_task(m_running, ST_SLEEP);
        pick_next_task();
      end
      OP_TICK: begin
        for (i = 0; i < m_used && i < 8; i++) begin
          if (m_state[i] != ST_SLEEP) continue;
          if (m_sleep[i] > 0) m_sleep[i]--;
          if (m_sleep[i] == 0) move_task(i, ST_READY);
        end
        pick_next_task();
      end
      OP_YIELD: pick_next_task();
      OP_SEMINIT: begin
        m_sem_lim[c.sem_index] = c.sem_max;
        m_sem_cnt[c.sem_index] = c.sem_initial;
      end
      OP_TAKE: begin
        if (m_sem_cnt[c.sem_index] > 0) m_sem_cnt[c.sem_index]--;
        else begin
          move_task(m_running, ST_BLOCK);
          m_wvalid[m_running] = 1;
          m_wsem[m_running] = c.sem_index;
          pick_next_task();
          r.status = STAT_SEMBUSY;
        end
      end
      OP_TRYTAKE: begin
        if (m_sem_cnt[c.sem_index] > 0) m_sem_cnt[c.sem_index]--;
        else r.status = STAT_SEMBUSY;
      end
      OP_GIVE: begin
        if (m_sem_cnt[c.sem_index] < m_sem_lim[c.sem_index]) begin
          m_sem_cnt[c.sem_index]++;
          for (i = 0; i < m_used && i < 8; i++)
            if (m_state[i] == ST_BLOCK && m_wvalid[i] && m_wsem[i] == c.sem_index) begin
              move_task(i, ST_READY);
              m_wvalid[i] = 0; m_wsem[i] = 0;
              break;
            end
        end
      end
      default: ;
    endcase
    r.current_task = m_running;
    r.ready_mask = m_bitmap;
    return r;
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    int sel;
    c = cmd_t'(44'({$urandom, $urandom}));
    sel = $urandom_range(0, 99);
    // Weighted toward commands that build up and cycle through tasks.
    if (sel < 14)      c.opcode = OP_CREATE;
    else if (sel < 20) c.opcode = OP_DELETE;
    else if (sel < 30) c.opcode = OP_SLEEP;
    else if (sel < 50) c.opcode = OP_TICK;
    else if (sel < 58) c.opcode = OP_YIELD;
    else if (sel < 64) c.opcode = OP_SEMINIT;
    else if (sel < 76) c.opcode = OP_TAKE;
    else if (sel < 84) c.opcode = OP_TRYTAKE;
    else if (sel < 97) c.opcode = OP_GIVE;
    else               c.opcode = 4'($urandom_range(9, 15));
    if ($urandom_range(0, 9) < 8) c.delay = 16'($urandom_range(0, 3));
    if (c.opcode == OP_SEMINIT && $urandom_range(0, 3) != 0) begin
      c.sem_max = 8'($urandom_range(0, 4));
      c.sem_initial = 8'($urandom_range(0, 2));
    end
    return c;
  endfunction

  function automatic cmd_t make_cmd(logic [3:0] op, logic [2:0] ti, logic [2:0] pr,
                                    logic [15:0] dl, logic [1:0] si,
                                    logic signed [7:0] mx, logic signed [7:0] iv);
    cmd_t c;
    c.opcode = op; c.task_index = ti; c.priority_req = pr; c.delay = dl;
    c.sem_index = si; c.sem_max = mx; c.sem_initial = iv;
    return c;
  endfunction

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    model_reset();
    // Directed part: idle-only scheduling, field extremes and every opcode.
    pending_cmds.push_back(make_cmd(OP_YIELD, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(OP_TICK, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(OP_CREATE, 0, 7, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(OP_CREATE, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(OP_CREATE, 0, 7, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(OP_YIELD, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(OP_YIELD, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(OP_SLEEP, 0, 0, 16'hFFFF, 0, 0, 0));
    pending_cmds.push_back(make_cmd(OP_SLEEP, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(OP_TICK, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(OP_SEMINIT, 0, 0, 0, 3, 127, -128));
    pending_cmds.push_back(make_cmd(OP_SEMINIT, 0, 0, 0, 0, -128, 127));
    pending_cmds.push_back(make_cmd(OP_TRYTAKE, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(OP_GIVE, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(OP_SEMINIT, 0, 0, 0, 1, 1, 0));
    pending_cmds.push_back(make_cmd(OP_TAKE, 0, 0, 0, 1, 0, 0));
    pending_cmds.push_back(make_cmd(OP_TRYTAKE, 0, 0, 0, 1, 0, 0));
    pending_cmds.push_back(make_cmd(OP_GIVE, 0, 0, 0, 1, 0, 0));
    pending_cmds.push_back(make_cmd(OP_GIVE, 0, 0, 0, 1, 0, 0));
    pending_cmds.push_back(make_cmd(OP_DELETE, 7, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(OP_DELETE, 3, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(4'hF, 7, 7, 16'hFFFF, 3, -1, -1));
    for (int i = 0; i < 8; i++)
      pending_cmds.push_back(make_cmd(OP_CREATE, 0, 3'(i), 0, 0, 0, 0));
    for (int i = 0; i < 1220; i++) pending_cmds.push_back(random_cmd());
  end

  // Command driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 0;
      {opcode_i, task_index_i, priority_req_i, delay_i, sem_index_i, sem_max_i,
       sem_initial_i} <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_results.push_back(run_command(cmd_t'({opcode_i, task_index_i,
          priority_req_i, delay_i, sem_index_i, sem_max_i, sem_initial_i})));
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_cmds.size() == 600 && !sender_paused) begin
          // Drain every outstanding result once before continuing.
          in_valid_i <= 0;
          if (expected_results.size() == 0 && !(in_valid_i && in_ready_o))
            sender_paused <= 1;
        end else if (pending_cmds.size() > 0 &&
                     (no_idle || $urandom_range(0, 99) >= 38)) begin
          {opcode_i, task_index_i, priority_req_i, delay_i, sem_index_i, sem_max_i,
           sem_initial_i} <= pending_cmds.pop_front();
          in_valid_i <= 1;
        end else begin
          in_valid_i <= 0;
        end
      end
    end
  end

  // Result monitor with receiver stalls.
  always @(posedge clk_i or negedge rst_ni) begin
    sched_result_t exp_r;
    if (!rst_ni) begin
      out_ready_i <= 0;
      hold_cycles <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("result with no command outstanding");
          failed = 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (status_o !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, status_o);
            failed = 1;
          end
          if (created_slot_o !== exp_r.created_slot) begin
            $error("created_slot: expected %0d, got %0d", exp_r.created_slot,
                   created_slot_o);
            failed = 1;
          end
          if (current_task_o !== exp_r.current_task) begin
            $error("current_task: expected %0d, got %0d", exp_r.current_task,
                   current_task_o);
            failed = 1;
          end
          if (ready_mask_o !== exp_r.ready_mask) begin
            $error("ready_mask: expected %h, got %h", exp_r.ready_mask, ready_mask_o);
            failed = 1;
          end
        end
      end
      hold_cycles <= hold_cycles + 1;
      rx_hold = (hold_cycles >= 3000 && hold_cycles < 3400);
      no_idle = (hold_cycles >= 6000 && hold_cycles < 9000);
      out_ready_i <= !rx_hold && (no_idle || $urandom_range(0, 99) >= 38);
    end
  end

  initial begin
    failed = 0;
    sender_paused = 0;
    @(posedge rst_ni);
    wait (pending_cmds.size() == 0 && !in_valid_i);
    wait (expected_results.size() == 0);
    repeat (50) @(posedge clk_i);
    if (!failed && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
